### hw/rtl/sci_pkg.sv
`default_nettype none
package sci_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  localparam int MODE_W = 2;
  localparam int IDX_W  = 10;
  localparam int SMP_W  = 32;
  localparam int POS_W  = 32;
  localparam int ANS_W  = 48;
  localparam int CNT_W  = 11;
  localparam int SPAN_W = 34;
  localparam int FRAC_W = 16;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_LOAD,
    MODE_VALUE,
    MODE_DERIV,
    MODE_INTEG
  } mode_t;

  typedef enum logic [1:0] {
    REG_X_START,
    REG_X_END,
    REG_POINT_COUNT
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FIN,
    S_MD_MUL,
    S_MD_DIV,
    S_MD_FIX,
    S_V_START,
    S_V_RDONE,
    S_V_I,
    S_V_RB,
    S_V_RC,
    S_V_FIN,
    S_VAL_DONE,
    S_D_DA,
    S_D_V1,
    S_D_V2,
    S_D_FIN,
    S_I_T2,
    S_I_M,
    S_I_E,
    S_I_SUM0,
    S_I_SUM,
    S_I_V,
    S_I_P1,
    S_I_P2
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/sci_in_if.sv
`default_nettype none
interface sci_in_if import sci_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [IDX_W-1:0]         sample_index;
  logic signed [SMP_W-1:0]  sample_value;
  logic signed [POS_W-1:0]  position;

  modport source (output valid, mode, sample_index, sample_value, position, input ready);
  modport sink (input valid, mode, sample_index, sample_value, position, output ready);
endinterface
`default_nettype wire

### hw/rtl/sci_out_if.sv
`default_nettype none
interface sci_out_if import sci_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ANS_W-1:0]  answer;
  logic                     status;

  modport source (output valid, answer, status, input ready);
  modport sink (input valid, answer, status, output ready);
endinterface
`default_nettype wire

### hw/rtl/sci_ram.sv
`default_nettype none
module sci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(DEPTH)-1:0]       waddr,
  input  wire logic [WIDTH-1:0]               wdata,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr,
  output logic      [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/sampled_curve_interpolator.sv
`default_nettype none
// channel   dir  beat contents
// in_chan   in   mode, sample_index, sample_value, position
// out_chan  out  answer, status (one beat per input beat)
// cfg       in   APB: x_start @0x0, x_end @0x4, point_count @0x8
//
// One item at a time. A multiply-divide pass (shift-add then, unless the divisor is 1,
// restoring divide, one bit a cycle) works on W-bit operands, W = 35 + log2(MAX_POINTS).
// The integral walks the table with one read a cycle.
// Synchronous active-low reset; the table needs no clearing pass.
// A finished beat waits in the output register; the next item is taken meanwhile.
module sampled_curve_interpolator import sci_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  sci_in_if.sink                 in_chan,
  sci_out_if.source              out_chan,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int TW = 35 + IW;
  localparam int MW = TW;
  localparam int PW = 2 * MW;
  localparam int QW = PW + 1;
  localparam int CW = $clog2(PW);

  logic signed [POS_W-1:0] xs_r, xe_r;
  logic [CNT_W-1:0]        pc_r;

  state_t state_r, state_nxt, md_ret_r, md_ret_nxt, v_ret_r, v_ret_nxt;

  logic signed [POS_W-1:0]  pos_r, pos_nxt;
  logic [IW-1:0]            ni_r, ni_nxt;
  logic signed [SPAN_W-1:0] span_r, span_nxt;
  logic signed [TW-1:0]     vpos_r, vpos_nxt, vres_r, vres_nxt, yi_r, yi_nxt;
  logic signed [TW-1:0]     v1_r, v1_nxt, t_r, t_nxt, e_r, e_nxt;
  logic signed [TW-1:0]     s_r, s_nxt, ym_r, ym_nxt, da_r, da_nxt;
  logic [MW-1:0]            rem_r, rem_nxt;
  logic [IW-1:0]            iidx_r, iidx_nxt, m_r, m_nxt, cnt_r, cnt_nxt, rd_k_r, rd_k_nxt;
  logic                     rd_pend_r, rd_pend_nxt, iss_done_r, iss_done_nxt;
  logic [MW-1:0]            md_a_r, md_a_nxt, md_b_r, md_b_nxt, md_c_r, md_c_nxt;
  logic [MW-1:0]            md_rem_r, md_rem_nxt;
  logic [PW-1:0]            md_acc_r, md_acc_nxt;
  logic [CW-1:0]            md_cnt_r, md_cnt_nxt;
  logic                     md_neg_r, md_neg_nxt;
  logic signed [QW-1:0]     md_q_r, md_q_nxt, p1_r, p1_nxt, res_r, res_nxt;
  logic                     res_st_r, res_st_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [ANS_W-1:0]  out_ans_r, out_ans_nxt;
  logic                     out_st_r, out_st_nxt;

  logic                     call_en, v_call;
  logic signed [TW-1:0]     call_a, call_b, v_pos;
  logic [MW-1:0]            call_c;
  state_t                   call_ret, v_ret;

  logic [31:0]              n_w;
  logic [IW-1:0]            ni_w;
  logic signed [SPAN_W-1:0] span_w;
  logic                     idx_ok, in_acc;

  logic                     ram_we;
  logic [IW-1:0]            rd_addr;
  logic [SMP_W-1:0]         ram_rdata;
  logic signed [TW-1:0]     y_rd, t_w;

  logic [PW-1:0]            md_addend;
  logic [MW:0]              md_remsh, md_sub;
  logic                     md_ge;
  logic [MW-1:0]            c_int;
  logic                     fits;
  logic signed [ANS_W-1:0]  sat_w;

  always_comb begin
    if (pc_r < CNT_W'(2)) begin
      n_w = 32'd2;
    end else if (32'(pc_r) > 32'(MAX_POINTS)) begin
      n_w = 32'(MAX_POINTS);
    end else begin
      n_w = 32'(pc_r);
    end
  end

  assign ni_w   = IW'(n_w - 32'd1);
  assign span_w = SPAN_W'(xe_r) - SPAN_W'(xs_r);
  assign idx_ok = 32'(in_chan.sample_index) < n_w;
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc = in_chan.valid && in_chan.ready;
  assign ram_we = in_acc && (mode_t'(in_chan.mode) == MODE_LOAD) && idx_ok;

  assign y_rd      = TW'($signed(ram_rdata));
  assign t_w       = TW'(md_q_r);
  assign c_int     = MW'({ni_r, {(FRAC_W + 1){1'b0}}});
  assign md_addend = md_b_r[MW-1] ? PW'(md_a_r) : '0;
  assign md_remsh  = {md_rem_r, md_acc_r[PW-1]};
  assign md_sub    = md_remsh - {1'b0, md_c_r};
  assign md_ge     = md_remsh >= {1'b0, md_c_r};

  assign fits  = (&res_r[QW-1:ANS_W-1]) || !(|res_r[QW-1:ANS_W-1]);
  assign sat_w = fits ? res_r[ANS_W-1:0] :
                 (res_r[QW-1] ? {1'b1, {(ANS_W-1){1'b0}}} : {1'b0, {(ANS_W-1){1'b1}}});

  sci_ram #(
    .WIDTH(SMP_W),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(IW'(in_chan.sample_index)),
    .wdata(in_chan.sample_value),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    md_ret_nxt   = md_ret_r;
    v_ret_nxt    = v_ret_r;
    pos_nxt      = pos_r;
    ni_nxt       = ni_r;
    span_nxt     = span_r;
    vpos_nxt     = vpos_r;
    vres_nxt     = vres_r;
    yi_nxt       = yi_r;
    v1_nxt       = v1_r;
    t_nxt        = t_r;
    e_nxt        = e_r;
    s_nxt        = s_r;
    ym_nxt       = ym_r;
    da_nxt       = da_r;
    rem_nxt      = rem_r;
    iidx_nxt     = iidx_r;
    m_nxt        = m_r;
    cnt_nxt      = cnt_r;
    rd_k_nxt     = rd_k_r;
    rd_pend_nxt  = rd_pend_r;
    iss_done_nxt = iss_done_r;
    md_a_nxt     = md_a_r;
    md_b_nxt     = md_b_r;
    md_c_nxt     = md_c_r;
    md_rem_nxt   = md_rem_r;
    md_acc_nxt   = md_acc_r;
    md_cnt_nxt   = md_cnt_r;
    md_neg_nxt   = md_neg_r;
    md_q_nxt     = md_q_r;
    p1_nxt       = p1_r;
    res_nxt      = res_r;
    res_st_nxt   = res_st_r;
    out_valid_nxt = out_valid_r;
    out_ans_nxt  = out_ans_r;
    out_st_nxt   = out_st_r;
    call_en      = 1'b0;
    call_a       = '0;
    call_b       = '0;
    call_c       = '0;
    call_ret     = S_IDLE;
    v_call       = 1'b0;
    v_pos        = '0;
    v_ret        = S_IDLE;
    rd_addr      = '0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pos_nxt    = in_chan.position;
          ni_nxt     = ni_w;
          span_nxt   = span_w;
          res_nxt    = '0;
          res_st_nxt = 1'b0;
          case (mode_t'(in_chan.mode))
            MODE_LOAD: begin
              res_st_nxt = !idx_ok;
              state_nxt  = S_FIN;
            end
            MODE_VALUE: begin
              v_call = 1'b1;
              v_pos  = TW'(in_chan.position);
              v_ret  = S_VAL_DONE;
            end
            MODE_DERIV: begin
              if (span_w <= 0) begin
                state_nxt = S_FIN;
              end else begin
                call_en  = 1'b1;
                call_a   = TW'(span_w);
                call_b   = TW'(1);
                call_c   = MW'(ni_w);
                call_ret = S_D_DA;
              end
            end
            MODE_INTEG: begin
              if (span_w <= 0) begin
                state_nxt = S_FIN;
              end else begin
                call_en  = 1'b1;
                call_a   = TW'(in_chan.position) - TW'(xs_r);
                call_b   = TW'(ni_w);
                call_c   = MW'(1);
                call_ret = S_I_T2;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_ans_nxt   = sat_w;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      S_MD_MUL: begin
        md_acc_nxt = {md_acc_r[PW-2:0], 1'b0} + md_addend;
        md_b_nxt   = {md_b_r[MW-2:0], 1'b0};
        md_cnt_nxt = md_cnt_r + CW'(1);
        if (md_cnt_r == CW'(MW - 1)) begin
          md_cnt_nxt = '0;
          state_nxt  = (md_c_r == MW'(1)) ? S_MD_FIX : S_MD_DIV;
        end
      end

      S_MD_DIV: begin
        md_rem_nxt = md_ge ? md_sub[MW-1:0] : md_remsh[MW-1:0];
        md_acc_nxt = {md_acc_r[PW-2:0], md_ge};
        md_cnt_nxt = md_cnt_r + CW'(1);
        if (md_cnt_r == CW'(PW - 1)) begin
          state_nxt = S_MD_FIX;
        end
      end

      S_MD_FIX: begin
        if (md_neg_r) begin
          md_q_nxt = -(QW'(md_acc_r) + QW'(md_rem_r != '0));
        end else begin
          md_q_nxt = QW'(md_acc_r);
        end
        state_nxt = md_ret_r;
      end

      S_V_START: begin
        if (vpos_r <= TW'(xs_r)) begin
          rd_addr   = '0;
          state_nxt = S_V_RDONE;
        end else if (vpos_r >= TW'(xe_r)) begin
          rd_addr   = ni_r;
          state_nxt = S_V_RDONE;
        end else begin
          call_en  = 1'b1;
          call_a   = vpos_r - TW'(xs_r);
          call_b   = TW'(ni_r);
          call_c   = MW'(span_r);
          call_ret = S_V_I;
        end
      end

      S_V_RDONE: begin
        vres_nxt  = y_rd;
        state_nxt = v_ret_r;
      end

      S_V_I: begin
        iidx_nxt  = md_q_r[IW-1:0];
        rem_nxt   = md_rem_r;
        rd_addr   = md_q_r[IW-1:0];
        state_nxt = S_V_RB;
      end

      S_V_RB: begin
        yi_nxt    = y_rd;
        rd_addr   = iidx_r + IW'(1);
        state_nxt = S_V_RC;
      end

      S_V_RC: begin
        call_en  = 1'b1;
        call_a   = y_rd - yi_r;
        call_b   = TW'(rem_r);
        call_c   = MW'(span_r);
        call_ret = S_V_FIN;
      end

      S_V_FIN: begin
        vres_nxt  = yi_r + t_w;
        state_nxt = v_ret_r;
      end

      S_VAL_DONE: begin
        res_nxt   = QW'(vres_r);
        state_nxt = S_FIN;
      end

      S_D_DA: begin
        da_nxt = t_w;
        if (md_q_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          v_call = 1'b1;
          v_pos  = TW'(pos_r) + t_w;
          v_ret  = S_D_V1;
        end
      end

      S_D_V1: begin
        v1_nxt = vres_r;
        v_call = 1'b1;
        v_pos  = TW'(pos_r) - da_r;
        v_ret  = S_D_V2;
      end

      S_D_V2: begin
        call_en  = 1'b1;
        call_a   = v1_r - vres_r;
        call_b   = TW'(1 << FRAC_W);
        call_c   = MW'({da_r, 1'b0});
        call_ret = S_D_FIN;
      end

      S_D_FIN: begin
        res_nxt   = md_q_r;
        state_nxt = S_FIN;
      end

      S_I_T2: begin
        t_nxt = t_w;
        if (t_w <= 0) begin
          m_nxt     = '0;
          e_nxt     = t_w;
          state_nxt = S_I_SUM0;
        end else begin
          call_en  = 1'b1;
          call_a   = t_w - TW'(1);
          call_b   = TW'(1);
          call_c   = MW'(span_r);
          call_ret = S_I_M;
        end
      end

      S_I_M: begin
        if (md_q_r > QW'(ni_r)) begin
          m_nxt    = ni_r;
          call_en  = 1'b1;
          call_a   = TW'(ni_r);
          call_b   = TW'(span_r);
          call_c   = MW'(1);
          call_ret = S_I_E;
        end else begin
          m_nxt     = md_q_r[IW-1:0];
          e_nxt     = TW'(md_rem_r) + TW'(1);
          state_nxt = S_I_SUM0;
        end
      end

      S_I_E: begin
        e_nxt     = t_r - t_w;
        state_nxt = S_I_SUM0;
      end

      S_I_SUM0: begin
        s_nxt        = '0;
        rd_addr      = '0;
        rd_pend_nxt  = 1'b1;
        rd_k_nxt     = '0;
        cnt_nxt      = IW'(1);
        iss_done_nxt = (m_r == '0);
        state_nxt    = S_I_SUM;
      end

      S_I_SUM: begin
        if (!iss_done_r) begin
          rd_addr      = cnt_r;
          rd_pend_nxt  = 1'b1;
          rd_k_nxt     = cnt_r;
          cnt_nxt      = cnt_r + IW'(1);
          iss_done_nxt = (cnt_r == m_r);
        end else begin
          rd_pend_nxt = 1'b0;
        end
        if (rd_pend_r) begin
          if (m_r == '0) begin
            s_nxt = s_r;
          end else if ((rd_k_r == '0) || (rd_k_r == m_r)) begin
            s_nxt = s_r + y_rd;
          end else begin
            s_nxt = s_r + (y_rd <<< 1);
          end
          if (rd_k_r == m_r) begin
            ym_nxt = y_rd;
            v_call = 1'b1;
            v_pos  = TW'(pos_r);
            v_ret  = S_I_V;
          end
        end
      end

      S_I_V: begin
        ym_nxt   = ym_r + vres_r;
        call_en  = 1'b1;
        call_a   = s_r;
        call_b   = TW'(span_r);
        call_c   = c_int;
        call_ret = S_I_P1;
      end

      S_I_P1: begin
        p1_nxt   = md_q_r;
        call_en  = 1'b1;
        call_a   = ym_r;
        call_b   = e_r;
        call_c   = c_int;
        call_ret = S_I_P2;
      end

      S_I_P2: begin
        res_nxt   = p1_r + md_q_r;
        state_nxt = S_FIN;
      end

      default: state_nxt = S_IDLE;
    endcase

    if (call_en) begin
      md_a_nxt   = call_a[TW-1] ? MW'(~call_a + TW'(1)) : MW'(call_a);
      md_b_nxt   = call_b[TW-1] ? MW'(~call_b + TW'(1)) : MW'(call_b);
      md_c_nxt   = call_c;
      md_neg_nxt = call_a[TW-1] ^ call_b[TW-1];
      md_acc_nxt = '0;
      md_rem_nxt = '0;
      md_cnt_nxt = '0;
      md_ret_nxt = call_ret;
      state_nxt  = S_MD_MUL;
    end

    if (v_call) begin
      vpos_nxt  = v_pos;
      v_ret_nxt = v_ret;
      state_nxt = S_V_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      xs_r        <= '0;
      xe_r        <= POS_W'(1 << FRAC_W);
      pc_r        <= CNT_W'(2);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      if (psel && penable && pwrite) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_X_START:     xs_r <= pwdata;
          REG_X_END:       xe_r <= pwdata;
          REG_POINT_COUNT: pc_r <= pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    md_ret_r   <= md_ret_nxt;
    v_ret_r    <= v_ret_nxt;
    pos_r      <= pos_nxt;
    ni_r       <= ni_nxt;
    span_r     <= span_nxt;
    vpos_r     <= vpos_nxt;
    vres_r     <= vres_nxt;
    yi_r       <= yi_nxt;
    v1_r       <= v1_nxt;
    t_r        <= t_nxt;
    e_r        <= e_nxt;
    s_r        <= s_nxt;
    ym_r       <= ym_nxt;
    da_r       <= da_nxt;
    rem_r      <= rem_nxt;
    iidx_r     <= iidx_nxt;
    m_r        <= m_nxt;
    cnt_r      <= cnt_nxt;
    rd_k_r     <= rd_k_nxt;
    iss_done_r <= iss_done_nxt;
    md_a_r     <= md_a_nxt;
    md_b_r     <= md_b_nxt;
    md_c_r     <= md_c_nxt;
    md_rem_r   <= md_rem_nxt;
    md_acc_r   <= md_acc_nxt;
    md_cnt_r   <= md_cnt_nxt;
    md_neg_r   <= md_neg_nxt;
    md_q_r     <= md_q_nxt;
    p1_r       <= p1_nxt;
    res_r      <= res_nxt;
    res_st_r   <= res_st_nxt;
    out_ans_r  <= out_ans_nxt;
    out_st_r   <= out_st_nxt;
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_X_START:     prdata = xs_r;
      REG_X_END:       prdata = xe_r;
      REG_POINT_COUNT: prdata = DATA_W'(pc_r);
      default:         prdata = '0;
    endcase
  end

  assign pready          = 1'b1;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.answer = out_ans_r;
  assign out_chan.status = out_st_r;

endmodule
`default_nettype wire
